FILE: src/elias_gamma_delta_bit_writer_unit_macros.svh
// Assertion macros for the bit writer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ELIAS_GAMMA_DELTA_BIT_WRITER_UNIT_MACROS_SVH
`define ELIAS_GAMMA_DELTA_BIT_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBW_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("bit writer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EBW_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("bit writer assertion failed");

`endif

FILE: src/ebw_pkg.sv
// Package for the bit writer: widths, command codes, microcode layout and the control store.
// No dependencies; imported by every module of the block.
package ebw_pkg;

    localparam int unsigned CmdW       = 3;
    localparam int unsigned ValueW     = 63;
    localparam int unsigned NbW        = 7;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned PcW        = 5;
    localparam int unsigned CntW       = 9;
    localparam int unsigned WordW      = 64;
    localparam int unsigned GroupW     = 16;
    localparam int unsigned GroupCnt   = WordW / GroupW;
    localparam int unsigned GroupIdxW  = $clog2(GroupCnt);
    localparam int unsigned MsbW       = $clog2(WordW);
    localparam int unsigned MaxUnary   = 256;
    localparam int unsigned MaxBinBits = 64;

    localparam logic [CmdW-1:0] CMD_UNARY  = 3'd0;
    localparam logic [CmdW-1:0] CMD_BINARY = 3'd1;
    localparam logic [CmdW-1:0] CMD_GAMMA  = 3'd2;
    localparam logic [CmdW-1:0] CMD_DELTA  = 3'd3;
    localparam logic [CmdW-1:0] CMD_BIT    = 3'd4;
    localparam logic [CmdW-1:0] CMD_FLUSH  = 3'd5;

    localparam logic [PcW-1:0] PC_U0  = 5'd0;
    localparam logic [PcW-1:0] PC_U1  = 5'd1;
    localparam logic [PcW-1:0] PC_U2  = 5'd2;
    localparam logic [PcW-1:0] PC_B0  = 5'd3;
    localparam logic [PcW-1:0] PC_B1  = 5'd4;
    localparam logic [PcW-1:0] PC_B2  = 5'd5;
    localparam logic [PcW-1:0] PC_G0  = 5'd6;
    localparam logic [PcW-1:0] PC_G1  = 5'd7;
    localparam logic [PcW-1:0] PC_G2  = 5'd8;
    localparam logic [PcW-1:0] PC_G3  = 5'd9;
    localparam logic [PcW-1:0] PC_G4  = 5'd10;
    localparam logic [PcW-1:0] PC_D0  = 5'd11;
    localparam logic [PcW-1:0] PC_D1  = 5'd12;
    localparam logic [PcW-1:0] PC_D2  = 5'd13;
    localparam logic [PcW-1:0] PC_D3  = 5'd14;
    localparam logic [PcW-1:0] PC_D4  = 5'd15;
    localparam logic [PcW-1:0] PC_D5  = 5'd16;
    localparam logic [PcW-1:0] PC_S0  = 5'd17;
    localparam logic [PcW-1:0] PC_F0  = 5'd18;
    localparam logic [PcW-1:0] PC_END = 5'd19;
    localparam logic [PcW-1:0] PC_ERR = 5'd20;

    typedef enum logic [2:0] {
        SK_NOP,
        SK_FIND,
        SK_SEG,
        SK_END,
        SK_ERR
    } step_kind_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_VALUE,
        SRC_KP1
    } src_sel_t;

    typedef enum logic [2:0] {
        CNT_UNARY,
        CNT_NB,
        CNT_K,
        CNT_J,
        CNT_ONE,
        CNT_PAD
    } cnt_sel_t;

    typedef enum logic [2:0] {
        CD_NEXT,
        CD_GOTO,
        CD_BAD_UNARY,
        CD_BAD_BINARY,
        CD_ZERO_VALUE
    } cond_t;

    typedef struct packed {
        step_kind_t       kind;
        src_sel_t         src;
        cnt_sel_t         cnt;
        cond_t            cond;
        logic [PcW-1:0]   target;
    } ucode_t;

    typedef struct packed {
        logic       busy;
        logic       accept;
        logic       first;
        step_kind_t kind;
        src_sel_t   src;
        cnt_sel_t   cnt;
    } dp_ctl_t;

    typedef struct packed {
        logic done;
        logic bad_unary;
        logic bad_binary;
        logic value_zero;
    } dp_stat_t;

    function automatic logic [PcW-1:0] ebw_entry(input logic [CmdW-1:0] cmd);
        logic [PcW-1:0] pc;
        case (cmd)
            CMD_UNARY:  pc = PC_U0;
            CMD_BINARY: pc = PC_B0;
            CMD_GAMMA:  pc = PC_G0;
            CMD_DELTA:  pc = PC_D0;
            CMD_BIT:    pc = PC_S0;
            CMD_FLUSH:  pc = PC_F0;
            default:    pc = PC_ERR;
        endcase
        return pc;
    endfunction

    function automatic ucode_t ebw_ucode(input logic [PcW-1:0] pc);
        ucode_t w;
        case (pc)
            PC_U0:   w = '{SK_NOP,  SRC_ZERO,  CNT_ONE,   CD_BAD_UNARY,  PC_ERR};
            PC_U1:   w = '{SK_SEG,  SRC_ZERO,  CNT_UNARY, CD_NEXT,       PC_END};
            PC_U2:   w = '{SK_SEG,  SRC_ONE,   CNT_ONE,   CD_GOTO,       PC_END};
            PC_B0:   w = '{SK_FIND, SRC_ZERO,  CNT_ONE,   CD_NEXT,       PC_END};
            PC_B1:   w = '{SK_NOP,  SRC_ZERO,  CNT_ONE,   CD_BAD_BINARY, PC_ERR};
            PC_B2:   w = '{SK_SEG,  SRC_VALUE, CNT_NB,    CD_GOTO,       PC_END};
            PC_G0:   w = '{SK_NOP,  SRC_ZERO,  CNT_ONE,   CD_ZERO_VALUE, PC_ERR};
            PC_G1:   w = '{SK_FIND, SRC_ZERO,  CNT_ONE,   CD_NEXT,       PC_END};
            PC_G2:   w = '{SK_SEG,  SRC_ZERO,  CNT_K,     CD_NEXT,       PC_END};
            PC_G3:   w = '{SK_SEG,  SRC_ONE,   CNT_ONE,   CD_NEXT,       PC_END};
            PC_G4:   w = '{SK_SEG,  SRC_VALUE, CNT_K,     CD_GOTO,       PC_END};
            PC_D0:   w = '{SK_NOP,  SRC_ZERO,  CNT_ONE,   CD_ZERO_VALUE, PC_ERR};
            PC_D1:   w = '{SK_FIND, SRC_ZERO,  CNT_ONE,   CD_NEXT,       PC_END};
            PC_D2:   w = '{SK_SEG,  SRC_ZERO,  CNT_J,     CD_NEXT,       PC_END};
            PC_D3:   w = '{SK_SEG,  SRC_ONE,   CNT_ONE,   CD_NEXT,       PC_END};
            PC_D4:   w = '{SK_SEG,  SRC_KP1,   CNT_J,     CD_NEXT,       PC_END};
            PC_D5:   w = '{SK_SEG,  SRC_VALUE, CNT_K,     CD_GOTO,       PC_END};
            PC_S0:   w = '{SK_SEG,  SRC_VALUE, CNT_ONE,   CD_GOTO,       PC_END};
            PC_F0:   w = '{SK_SEG,  SRC_ZERO,  CNT_PAD,   CD_GOTO,       PC_END};
            PC_ERR:  w = '{SK_ERR,  SRC_ZERO,  CNT_ONE,   CD_NEXT,       PC_END};
            default: w = '{SK_END,  SRC_ZERO,  CNT_ONE,   CD_NEXT,       PC_END};
        endcase
        return w;
    endfunction

    function automatic logic [$clog2(GroupW)-1:0] ebw_msb16(input logic [GroupW-1:0] v);
        logic [$clog2(GroupW)-1:0] p;
        p = '0;
        for (int i = 0; i < GroupW; i++) begin
            if (v[i]) begin
                p = ($clog2(GroupW))'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: src/elias_gamma_delta_bit_writer_unit.sv
// Top level of the MSB-first bit writer with unary, binary, Elias gamma and delta codes.
// Depends on ebw_pkg, ebw_sequencer and ebw_datapath.
//
//  Group  Dir  Signals                          Contents
//  s_*    in   s_tvalid s_tready s_tdata s_tuser  one command beat
//  m_*    out  m_tvalid m_tready m_tdata m_tuser  one packed byte or error beat, m_tlast
//
// One command is worked at a time; s_tready is high only while the sequencer is idle.
// Each command runs as a sequence of microcode steps; a bit field step packs its field in pieces
// that end on a byte boundary or at the end of the field, and the leading-one search scans the
// value one 16-bit group at a time from the top.
// Every finished byte waits in a hold register so that the final one of a command can
// carry m_tlast; a stalled m_tready pauses the field shifter without losing bits.
// Reset clears the pending bits and leaves the block idle with no output beat.
module elias_gamma_delta_bit_writer_unit import ebw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value [62:0], num_bits [69:63], zero pad [71:70]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tuser,   // error [0]
    output logic        m_tlast
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    ebw_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .cmd      (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ebw_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .value    (s_tdata[ValueW-1:0]),
        .num_bits (s_tdata[ValueW +: NbW]),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/ebw_msb_finder.sv
// Leading-one search over the value word, one 16-bit group per cycle from the top.
// Depends on ebw_pkg.
module ebw_msb_finder import ebw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ValueW-1:0] value,
    output logic              done,
    output logic [MsbW-1:0]   msb
);

    logic                 busy_reg, busy_next;
    logic [GroupIdxW-1:0] group_reg, group_next;
    logic [MsbW-1:0]      msb_reg, msb_next;
    logic [WordW-1:0]     word;
    logic [GroupW-1:0]    grp;
    logic                 hit;

    assign word = {{(WordW - ValueW){1'b0}}, value};
    assign grp  = word[group_reg * GroupW +: GroupW];
    assign hit  = busy_reg && ((grp != '0) || (group_reg == '0));
    assign done = hit;
    assign msb  = msb_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        group_next = group_reg;
        msb_next   = msb_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            group_next = GroupIdxW'(GroupCnt - 1);
        end
        else if (hit)
        begin
            busy_next = 1'b0;
            msb_next  = {group_reg, ebw_msb16(grp)};
        end
        else if (busy_reg)
        begin
            group_next = group_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            group_reg <= '0;
            msb_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            group_reg <= group_next;
            msb_reg   <= msb_next;
        end
    end

endmodule

FILE: src/ebw_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on ebw_pkg.
module ebw_sequencer import ebw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic [CmdW-1:0] cmd,
    output logic            s_tready,
    input  dp_stat_t        stat,
    output dp_ctl_t         ctl
);

    logic [PcW-1:0] pc_reg, pc_next;
    logic           busy_reg, busy_next;
    logic           first_reg, first_next;
    ucode_t         word;
    logic           accept;
    logic           cond_hit;
    logic           finishing;

    assign word      = ebw_ucode(pc_reg);
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && !busy_reg;
    assign finishing = (word.kind == SK_END) || (word.kind == SK_ERR);

    always_comb
    begin
        case (word.cond)
            CD_NEXT:       cond_hit = 1'b0;
            CD_GOTO:       cond_hit = 1'b1;
            CD_BAD_UNARY:  cond_hit = stat.bad_unary;
            CD_BAD_BINARY: cond_hit = stat.bad_binary;
            CD_ZERO_VALUE: cond_hit = stat.value_zero;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next    = pc_reg;
        busy_next  = busy_reg;
        first_next = 1'b0;
        if (!busy_reg)
        begin
            if (s_tvalid)
            begin
                pc_next    = ebw_entry(cmd);
                busy_next  = 1'b1;
                first_next = 1'b1;
            end
        end
        else if (stat.done)
        begin
            if (finishing)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next    = cond_hit ? word.target : pc_reg + 1'b1;
                first_next = 1'b1;
            end
        end
    end

    assign ctl.busy   = busy_reg;
    assign ctl.accept = accept;
    assign ctl.first  = first_reg;
    assign ctl.kind   = word.kind;
    assign ctl.src    = word.src;
    assign ctl.cnt    = word.cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_END;
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            busy_reg  <= busy_next;
            first_reg <= first_next;
        end
    end

endmodule

FILE: src/ebw_datapath.sv
// Datapath: operand registers, bit field shifter, byte accumulator, hold byte and output stage.
// Depends on ebw_pkg, ebw_msb_finder and the assertion macro header.
`include "elias_gamma_delta_bit_writer_unit_macros.svh"

module ebw_datapath import ebw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_ctl_t           ctl,
    input  logic [ValueW-1:0] value,
    input  logic [NbW-1:0]    num_bits,
    output dp_stat_t          stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ByteW-1:0]  m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic [ValueW-1:0] value_reg, value_next;
    logic [NbW-1:0]    nb_reg, nb_next;
    logic [ByteW-1:0]  acc_reg, acc_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [CntW-1:0]   rem_reg, rem_next;
    logic [WordW-1:0]  sr_reg, sr_next;
    logic [ByteW-1:0]  hold_reg, hold_next;
    logic              hold_valid_reg, hold_valid_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ByteW-1:0]  m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    logic              find_start;
    logic              find_done;
    logic [MsbW-1:0]   k;
    logic [MsbW-1:0]   kp1;
    logic [2:0]        j;
    logic [CntW-1:0]   seg_count;
    logic [WordW-1:0]  seg_src;
    logic [3:0]        free;
    logic [3:0]        take;
    logic [CntW-1:0]   sh;
    logic [WordW-1:0]  shv;
    logic [ByteW-1:0]  mask;
    logic [ByteW-1:0]  chunk;
    logic [ByteW-1:0]  acc_new;
    logic [3:0]        cnt_sum;
    logic              full;
    logic              out_free;
    logic              seg_run;
    logic              seg_stall;
    logic              last_chunk;
    logic              step_done;

    assign find_start = ctl.busy && ctl.first && (ctl.kind == SK_FIND);

    ebw_msb_finder u_finder
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (find_start),
        .value (value_reg),
        .done  (find_done),
        .msb   (k)
    );

    assign kp1 = k + 1'b1;
    assign j   = 3'(ebw_msb16(GroupW'(kp1)));

    always_comb
    begin
        case (ctl.cnt)
            CNT_UNARY: seg_count = value_reg[CntW-1:0] - 1'b1;
            CNT_NB:    seg_count = CntW'(nb_reg);
            CNT_K:     seg_count = CntW'(k);
            CNT_J:     seg_count = CntW'(j);
            CNT_ONE:   seg_count = CntW'(1);
            CNT_PAD:   seg_count = (cnt_reg == '0) ? '0 : CntW'(4'd8 - {1'b0, cnt_reg});
            default:   seg_count = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.src)
            SRC_ZERO:  seg_src = '0;
            SRC_ONE:   seg_src = WordW'(1);
            SRC_VALUE: seg_src = WordW'(value_reg);
            SRC_KP1:   seg_src = WordW'(kp1);
            default:   seg_src = '0;
        endcase
    end

    assign free       = 4'd8 - {1'b0, cnt_reg};
    assign take       = (rem_reg < CntW'(free)) ? rem_reg[3:0] : free;
    assign sh         = rem_reg - CntW'(take);
    assign shv        = sr_reg >> sh[MsbW-1:0];
    assign mask       = ByteW'((16'd1 << take) - 16'd1);
    assign chunk      = shv[ByteW-1:0] & mask;
    assign acc_new    = ByteW'((16'(acc_reg) << take) | 16'(chunk));
    assign cnt_sum    = {1'b0, cnt_reg} + take;
    assign full       = (cnt_sum == 4'd8);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign seg_run    = ctl.busy && (ctl.kind == SK_SEG) && !ctl.first;
    assign seg_stall  = seg_run && full && hold_valid_reg && !out_free;
    assign last_chunk = (rem_reg == CntW'(take));

    assign stat.bad_unary  = (value_reg == '0) || (value_reg > ValueW'(MaxUnary));
    assign stat.bad_binary = (nb_reg == '0) || (nb_reg > NbW'(MaxBinBits))
                             || (NbW'(k) >= nb_reg);
    assign stat.value_zero = (value_reg == '0);
    assign stat.done       = step_done;

    always_comb
    begin
        case (ctl.kind)
            SK_NOP:  step_done = 1'b1;
            SK_FIND: step_done = find_done;
            SK_SEG:  step_done = ctl.first ? (seg_count == '0) : (!seg_stall && last_chunk);
            SK_END:  step_done = !hold_valid_reg || out_free;
            SK_ERR:  step_done = out_free;
            default: step_done = 1'b1;
        endcase
    end

    always_comb
    begin
        value_next      = value_reg;
        nb_next         = nb_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        sr_next         = sr_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (ctl.accept)
        begin
            value_next = value;
            nb_next    = num_bits;
        end

        if (ctl.busy)
        begin
            case (ctl.kind)
                SK_SEG:
                begin
                    if (ctl.first)
                    begin
                        rem_next = seg_count;
                        sr_next  = seg_src;
                    end
                    else if (!seg_stall)
                    begin
                        rem_next = rem_reg - CntW'(take);
                        if (full)
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (hold_valid_reg)
                            begin
                                m_tvalid_next = 1'b1;
                                m_tdata_next  = hold_reg;
                                m_tuser_next  = 1'b0;
                                m_tlast_next  = 1'b0;
                            end
                            hold_next       = acc_new;
                            hold_valid_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_new;
                            cnt_next = cnt_sum[2:0];
                        end
                    end
                end
                SK_END:
                begin
                    if (hold_valid_reg && out_free)
                    begin
                        m_tvalid_next   = 1'b1;
                        m_tdata_next    = hold_reg;
                        m_tuser_next    = 1'b0;
                        m_tlast_next    = 1'b1;
                        hold_valid_next = 1'b0;
                    end
                end
                SK_ERR:
                begin
                    if (out_free)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = 1'b1;
                        m_tlast_next  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        nb_reg      <= nb_next;
        rem_reg     <= rem_next;
        sr_reg      <= sr_next;
        hold_reg    <= hold_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `EBW_ASSERT_IMP(a_err_beat, clk, rst_n, m_tvalid_reg && m_tuser_reg, m_tlast_reg && (m_tdata_reg == '0))
    `EBW_ASSERT_IMP(a_idle_no_hold, clk, rst_n, !ctl.busy, !hold_valid_reg)
    `EBW_ASSERT_IMP(a_seg_has_bits, clk, rst_n, seg_run, rem_reg != '0)
    `EBW_ASSERT_NXT(a_stall_holds, clk, rst_n, seg_stall, $stable(acc_reg) && $stable(rem_reg))

endmodule

FILE: bench/tb_elias_gamma_delta_bit_writer_unit.sv
`timescale 1ns / 100ps
// Testbench for elias_gamma_delta_bit_writer_unit: directed and random code-word commands with
// random idling on both streams, every output beat checked against an in-bench bit packer.
// Depends on ebw_pkg and the elias_gamma_delta_bit_writer_unit RTL.
module tb_elias_gamma_delta_bit_writer_unit;
    import ebw_pkg::*;

    localparam logic [CmdW-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CmdW-1:0] CMD_SPARE7 = 3'd7;
    localparam int RandomItems = 205;
    localparam int TailItems   = 30;
    localparam int DrainCycles = 200;
    localparam int PrintCap    = 40;

    typedef struct {
        logic [CmdW-1:0]   cmd;
        logic [ValueW-1:0] value;
        logic [NbW-1:0]    nb;
    } code_cmd_t;

    typedef struct {
        logic [ByteW-1:0] data;
        logic             err;
        logic             last;
    } byte_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    code_cmd_t  cmd_q[$];
    code_cmd_t  cmd_on_bus;
    byte_beat_t byte_q[$];
    byte_beat_t burst_q[$];
    byte_beat_t beat_want;

    logic [ByteW-1:0] pend_acc = '0;
    int pend_cnt       = 0;
    int cmds_accepted  = 0;
    int cmds_rejected  = 0;
    int beats_checked  = 0;
    int mismatches     = 0;
    int src_gap        = 0;
    int src_run        = 0;
    int sink_gap       = 0;
    int sink_run       = 0;
    logic calm         = 1'b0;

    elias_gamma_delta_bit_writer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int top_bit(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 1; i < 64; i++)
        begin
            if (v[i])
            begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic void pack_bit(input logic b);
        pend_acc = {pend_acc[ByteW-2:0], b};
        pend_cnt++;
        if (pend_cnt == ByteW)
        begin
            burst_q.push_back('{data: pend_acc, err: 1'b0, last: 1'b0});
            pend_acc = '0;
            pend_cnt = 0;
        end
    endfunction

    function automatic void pack_field(input logic [63:0] v, input int k);
        for (int i = k - 1; i >= 0; i--)
        begin
            pack_bit(v[i]);
        end
    endfunction

    function automatic void pack_unary(input int n);
        for (int i = 1; i < n; i++)
        begin
            pack_bit(1'b0);
        end
        pack_bit(1'b1);
    endfunction

    function automatic void pack_gamma(input logic [63:0] v);
        int k;
        k = top_bit(v);
        pack_unary(k + 1);
        pack_field(v, k);
    endfunction

    // Checks come first, so a rejected command never touches the pending bits.
    function automatic void predict_bytes(input code_cmd_t c);
        logic [63:0]      v;
        logic [ByteW-1:0] padded;
        int               nb;
        int               k;
        logic             bad;
        v = {1'b0, c.value};
        nb = int'(c.nb);
        bad = 1'b0;
        burst_q.delete();
        case (c.cmd)
            CMD_UNARY:
            begin
                if (v == 64'd0 || v > 64'(MaxUnary))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    pack_unary(int'(v));
                end
            end
            CMD_BINARY:
            begin
                if (nb == 0 || nb > int'(MaxBinBits) || top_bit(v) >= nb)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    pack_field(v, nb);
                end
            end
            CMD_GAMMA:
            begin
                if (v == 64'd0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    pack_gamma(v);
                end
            end
            CMD_DELTA:
            begin
                if (v == 64'd0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    k = top_bit(v);
                    pack_gamma(64'(k + 1));
                    pack_field(v, k);
                end
            end
            CMD_BIT:
            begin
                pack_bit(v[0]);
            end
            CMD_FLUSH:
            begin
                if (pend_cnt > 0)
                begin
                    padded = pend_acc << (ByteW - pend_cnt);
                    burst_q.push_back('{data: padded, err: 1'b0, last: 1'b0});
                    pend_acc = '0;
                    pend_cnt = 0;
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        if (bad)
        begin
            cmds_rejected++;
            byte_q.push_back('{data: '0, err: 1'b1, last: 1'b1});
        end
        else if (burst_q.size() > 0)
        begin
            burst_q[burst_q.size() - 1].last = 1'b1;
            foreach (burst_q[i])
            begin
                byte_q.push_back(burst_q[i]);
            end
        end
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 3) == 0)
        begin
            return int'($urandom_range(20, 60));
        end
        return int'($urandom_range(0, 6));
    endfunction

    function automatic logic [ValueW-1:0] rand_value(input int w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        r = r & ((64'd1 << w) - 64'd1);
        r[w-1] = 1'b1;
        return r[ValueW-1:0];
    endfunction

    function automatic int rand_width();
        if ($urandom_range(0, 3) == 0)
        begin
            return int'($urandom_range(1, ValueW));
        end
        return int'($urandom_range(1, 12));
    endfunction

    function automatic void push_cmd(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value,
                                     input logic [NbW-1:0] nb);
        cmd_q.push_back('{cmd: cmd, value: value, nb: nb});
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PrintCap)
        begin
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            calm     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cmds_accepted++;
                predict_bytes(cmd_on_bus);
            end
            calm <= (cmd_q.size() < TailItems);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    cmd_on_bus = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cmd_on_bus.nb, cmd_on_bus.value};
                    s_tuser  <= cmd_on_bus.cmd;
                    if (cmd_q.size() >= TailItems)
                    begin
                        if (src_run > 0)
                        begin
                            src_run--;
                        end
                        else
                        begin
                            src_gap = int'($urandom_range(1, 5));
                            src_run = pick_run();
                        end
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                if (byte_q.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", m_tdata, 8'h00);
                end
                else
                begin
                    beat_want = byte_q.pop_front();
                    if (m_tdata !== beat_want.data)
                    begin
                        report_mismatch("out_byte", m_tdata, beat_want.data);
                    end
                    if (m_tuser !== beat_want.err)
                    begin
                        report_mismatch("error flag", 8'(m_tuser), 8'(beat_want.err));
                    end
                    if (m_tlast !== beat_want.last)
                    begin
                        report_mismatch("last flag", 8'(m_tlast), 8'(beat_want.last));
                    end
                end
            end
            if (calm)
            begin
                m_tready <= 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_run > 0)
                begin
                    sink_run--;
                end
                else
                begin
                    sink_gap = int'($urandom_range(1, 5));
                    sink_run = pick_run();
                end
            end
        end
    end

    initial
    begin
        #(2_000_000);
        $display("elias_gamma_delta_bit_writer_unit regression: fail");
        $finish;
    end

    initial
    begin
        int pick;
        int w;
        int nb;
        logic [ValueW-1:0] v;
        logic [NbW-1:0] nb_noise;

        // Directed part: field extremes, every command and each rejection.
        push_cmd(CMD_FLUSH,  63'd0, 7'd0);
        push_cmd(CMD_BIT,    63'd1, 7'h7F);
        push_cmd(CMD_FLUSH,  63'd0, 7'd0);
        push_cmd(CMD_UNARY,  63'd1, 7'd0);
        push_cmd(CMD_UNARY,  63'(MaxUnary), 7'd0);
        push_cmd(CMD_UNARY,  63'd0, 7'd0);
        push_cmd(CMD_UNARY,  63'(MaxUnary + 1), 7'd0);
        push_cmd(CMD_UNARY,  63'h7FFF_FFFF_FFFF_FFFF, 7'h7F);
        push_cmd(CMD_BINARY, 63'd0, 7'd1);
        push_cmd(CMD_BINARY, 63'h7FFF_FFFF_FFFF_FFFF, 7'd64);
        push_cmd(CMD_BINARY, 63'h4000_0000_0000_0000, 7'd63);
        push_cmd(CMD_BINARY, 63'h4000_0000_0000_0000, 7'd62);
        push_cmd(CMD_BINARY, 63'd5, 7'd0);
        push_cmd(CMD_BINARY, 63'd0, 7'd65);
        push_cmd(CMD_BINARY, 63'd0, 7'h7F);
        push_cmd(CMD_GAMMA,  63'd1, 7'd0);
        push_cmd(CMD_GAMMA,  63'h7FFF_FFFF_FFFF_FFFF, 7'd0);
        push_cmd(CMD_GAMMA,  63'd0, 7'd0);
        push_cmd(CMD_DELTA,  63'd1, 7'd0);
        push_cmd(CMD_DELTA,  63'h7FFF_FFFF_FFFF_FFFF, 7'd0);
        push_cmd(CMD_DELTA,  63'd0, 7'd0);
        push_cmd(CMD_BIT,    63'h7FFF_FFFF_FFFF_FFFE, 7'd0);
        push_cmd(CMD_SPARE6, 63'd3, 7'd3);
        push_cmd(CMD_SPARE7, 63'h7FFF_FFFF_FFFF_FFFF, 7'h7F);
        push_cmd(CMD_FLUSH,  63'd0, 7'd0);
        push_cmd(CMD_FLUSH,  63'd0, 7'd0);

        // Random part: mostly well-formed code words, with a sprinkling of rejections.
        for (int i = 0; i < RandomItems; i++)
        begin
            pick = int'($urandom_range(0, 99));
            nb_noise = NbW'($urandom);
            if (pick < 16)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    v = ($urandom_range(0, 1) == 0) ? 63'd0 :
                        63'($urandom_range(MaxUnary + 1, 1000));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    v = 63'($urandom_range(1, MaxUnary));
                end
                else
                begin
                    v = 63'($urandom_range(1, 20));
                end
                push_cmd(CMD_UNARY, v, nb_noise);
            end
            else if (pick < 34)
            begin
                nb = int'($urandom_range(1, MaxBinBits));
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       push_cmd(CMD_BINARY, rand_value(rand_width()), 7'd0);
                        1:       push_cmd(CMD_BINARY, rand_value(rand_width()),
                                          7'($urandom_range(MaxBinBits + 1, 127)));
                        default:
                        begin
                            nb = int'($urandom_range(1, ValueW - 1));
                            w = int'($urandom_range(nb + 1, ValueW));
                            push_cmd(CMD_BINARY, rand_value(w), 7'(nb));
                        end
                    endcase
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    push_cmd(CMD_BINARY, 63'd0, 7'(nb));
                end
                else
                begin
                    w = int'($urandom_range(1, (nb < ValueW) ? nb : ValueW));
                    push_cmd(CMD_BINARY, rand_value(w), 7'(nb));
                end
            end
            else if (pick < 54)
            begin
                v = ($urandom_range(0, 24) == 0) ? 63'd0 : rand_value(rand_width());
                push_cmd(CMD_GAMMA, v, nb_noise);
            end
            else if (pick < 72)
            begin
                v = ($urandom_range(0, 24) == 0) ? 63'd0 : rand_value(rand_width());
                push_cmd(CMD_DELTA, v, nb_noise);
            end
            else if (pick < 88)
            begin
                push_cmd(CMD_BIT, ValueW'({$urandom, $urandom}), nb_noise);
            end
            else if (pick < 97)
            begin
                push_cmd(CMD_FLUSH, ValueW'({$urandom, $urandom}), nb_noise);
            end
            else
            begin
                push_cmd(($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7,
                         ValueW'({$urandom, $urandom}), nb_noise);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() > 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (byte_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        $display("Run covered %0d commands, %0d of them rejected, and %0d output beats.",
                 cmds_accepted, cmds_rejected, beats_checked);
        $display("Both streams idled in short bursts before a final stretch at full rate.");
        if (mismatches == 0 && byte_q.size() == 0)
        begin
            $display("elias_gamma_delta_bit_writer_unit regression: pass");
        end
        else
        begin
            $display("elias_gamma_delta_bit_writer_unit regression: fail");
        end
        $finish;
    end

endmodule
